// ===== src/vector_axis_angle_rotation_assert.svh =====
// Assertion macros for the axis-angle rotation block
`ifndef VECTOR_AXIS_ANGLE_ROTATION_ASSERT_SVH
`define VECTOR_AXIS_ANGLE_ROTATION_ASSERT_SVH

// condition must hold on every enabled edge
`define VAAR_ASSERT_HOLD(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define VAAR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/vaar_pkg.sv =====
// Types, constants and helpers for the axis-angle rotation pipeline
package vaar_pkg;

   localparam int STEPS_PER_STAGE = 4;
   localparam int CORDIC_STEPS    = 30;
   localparam int DIV_STEPS       = 31;
   localparam int LOOP_STAGES     = 8;
   localparam int DIV_STAGES      = 8;
   localparam int PIPE_DEPTH      = 13 + LOOP_STAGES + DIV_STAGES;

   localparam logic [29:0]        ANG_TO_TURN  = 30'd683565276;
   localparam logic signed [33:0] CORDIC_GAIN  = 34'sh026DD3B6A;
   localparam logic signed [33:0] ONE_Q30      = 34'sh040000000;
   localparam logic signed [33:0] NEG_ONE_Q30  = -34'sh040000000;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic [2:0][31:0] vec;
      logic [2:0][31:0] amag;
      logic [2:0]       aneg;
      logic             zero;
   } carry_type;

   typedef struct packed {
      carry_type          cr;
      logic [63:0]        l2;
      logic [35:0]        sq_rem;
      logic [31:0]        sq_root;
      logic signed [33:0] cx;
      logic signed [33:0] cy;
      logic signed [32:0] cz;
      logic [1:0]         quad;
   } iter_type;

   typedef struct packed {
      carry_type          cr;
      logic [31:0]        root;
      logic [2:0][32:0]   rem;
      logic [2:0][30:0]   quo;
      logic signed [31:0] cosv;
      logic signed [31:0] sinv;
   } div_type;

   function automatic logic [29:0] atan_turn(input logic [4:0] idx);
      logic [29:0] r;
      case (idx)
         5'd0:  r = 30'h20000000;
         5'd1:  r = 30'h12E4051E;
         5'd2:  r = 30'h09FB385B;
         5'd3:  r = 30'h051111D4;
         5'd4:  r = 30'h028B0D43;
         5'd5:  r = 30'h0145D7E1;
         5'd6:  r = 30'h00A2F61E;
         5'd7:  r = 30'h00517C55;
         5'd8:  r = 30'h0028BE53;
         5'd9:  r = 30'h00145F2F;
         5'd10: r = 30'h000A2F98;
         5'd11: r = 30'h000517CC;
         5'd12: r = 30'h00028BE6;
         5'd13: r = 30'h000145F3;
         5'd14: r = 30'h0000A2FA;
         5'd15: r = 30'h0000517D;
         5'd16: r = 30'h000028BE;
         5'd17: r = 30'h0000145F;
         5'd18: r = 30'h00000A30;
         5'd19: r = 30'h00000518;
         5'd20: r = 30'h0000028C;
         5'd21: r = 30'h00000146;
         5'd22: r = 30'h000000A3;
         5'd23: r = 30'h00000051;
         5'd24: r = 30'h00000029;
         5'd25: r = 30'h00000014;
         5'd26: r = 30'h0000000A;
         5'd27: r = 30'h00000005;
         5'd28: r = 30'h00000003;
         5'd29: r = 30'h00000001;
         default: r = 30'h00000000;
      endcase
      return r;
   endfunction

   // round to nearest, ties up: floor((p + 2^(n-1)) / 2^n)
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p,
                                                    input logic [4:0] n);
      return (p + (64'sd1 <<< (n - 5'd1))) >>> n;
   endfunction

   function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] x);
      logic signed [31:0] r;
      if (x > ONE_Q30) r = ONE_Q30[31:0];
      else if (x < NEG_ONE_Q30) r = NEG_ONE_Q30[31:0];
      else r = x[31:0];
      return r;
   endfunction

endpackage

// ===== src/vector_axis_angle_rotation.sv =====
// Axis-angle vector rotation (Rodrigues) as a fully pipelined stream block
//
// req_ carries one item per handshake: a Q16.16 vector, a Q16.16 axis of any
// length and a Q8.24 angle in radians. rsp_ returns the rotated vector,
// saturated to Q16.16, with flags for a zero axis and for saturation.
// One item is taken per cycle unless a result waits unaccepted at the
// output. The depth is set by the square root of the axis length (32 digit
// steps) and the three normalising divisions (31 steps), both run at four
// steps per stage; the CORDIC for sine and cosine runs beside the root.
// A zero axis gives a zero vector with zero_axis set.
// The whole pipeline advances together: while a result sits unaccepted at
// the output, every stage holds and req_tready is low, so nothing is lost
// or repeated. A bubble at the output lets the pipe close up.
// Reset clears the valid bits only; no result is presented until new items
// arrive.
module vector_axis_angle_rotation
   import vaar_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle
   input  logic [223:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x, out_y, out_z
   output logic [95:0]  rsp_tdata,
   // zero_axis, clipped
   output logic [1:0]   rsp_tuser
);

`include "vector_axis_angle_rotation_assert.svh"

   logic                  ce;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;

   assign ce         = !vld_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = ce;
   assign rsp_tvalid = vld_ff[PIPE_DEPTH-1];
   assign vld_in     = {vld_ff[PIPE_DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= vld_in;
      end
   end

   // stage 0: input register
   logic [2:0][31:0] vec0_ff, axis0_ff;
   logic [31:0]      ang0_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         vec0_ff  <= req_tdata[95:0];
         axis0_ff <= req_tdata[191:96];
         ang0_ff  <= req_tdata[223:192];
      end
   end

   // stage 1: magnitudes, largest magnitude, angle to turn fraction
   logic [2:0][31:0]   mag1_in, vec1_ff, mag1_ff;
   logic [2:0]         aneg1_ff;
   logic [31:0]        m1_in, m1_ff;
   logic signed [63:0] prod1_in, prod1_ff;

   always_comb begin
      m1_in = '0;
      for (int l = 0; l < 3; l++) begin
         mag1_in[l] = axis0_ff[l][31] ? (32'd0 - axis0_ff[l]) : axis0_ff[l];
         if (mag1_in[l] > m1_in) m1_in = mag1_in[l];
      end
      prod1_in = $signed(ang0_ff) * $signed({2'b00, ANG_TO_TURN});
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         vec1_ff  <= vec0_ff;
         mag1_ff  <= mag1_in;
         aneg1_ff <= {axis0_ff[2][31], axis0_ff[1][31], axis0_ff[0][31]};
         m1_ff    <= m1_in;
         prod1_ff <= prod1_in;
      end
   end

   // stage 2: common axis shift, phase and quadrant
   iter_type s2_in, s2_ff;

   always_comb begin
      logic [4:0]  msb;
      logic [4:0]  sh;
      logic        pow2;
      logic [63:0] ptmp;
      logic [31:0] phase;
      logic [31:0] qsum;
      logic [31:0] resid;
      msb = '0;
      for (int b = 0; b < 32; b++) begin
         if (m1_ff[b]) msb = 5'(b);
      end
      pow2 = ((m1_ff & (m1_ff - 32'd1)) == 32'd0);
      sh   = pow2 ? (5'd31 - msb) : (5'd30 - msb);
      s2_in          = '0;
      s2_in.cr.vec   = vec1_ff;
      s2_in.cr.aneg  = aneg1_ff;
      s2_in.cr.zero  = (m1_ff == 32'd0);
      for (int l = 0; l < 3; l++) begin
         s2_in.cr.amag[l] = mag1_ff[l] << sh;
      end
      ptmp  = prod1_ff + 64'd8388608;
      phase = ptmp[55:24];
      qsum  = phase + 32'h20000000;
      s2_in.quad = qsum[31:30];
      resid      = phase - {qsum[31:30], 30'd0};
      s2_in.cz   = 33'($signed(resid));
      s2_in.cx   = CORDIC_GAIN;
      s2_in.cy   = '0;
   end

   always_ff @(posedge clock) begin
      if (ce) s2_ff <= s2_in;
   end

   // stage 3: squares of the shifted axis
   iter_type         s3_ff;
   logic [2:0][63:0] sqr_in, sqr_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         sqr_in[l] = {32'd0, s2_ff.cr.amag[l]} * {32'd0, s2_ff.cr.amag[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s3_ff  <= s2_ff;
         sqr_ff <= sqr_in;
      end
   end

   // stage 4 and loop stages: square root digits beside CORDIC steps
   iter_type lp_in [0:LOOP_STAGES];
   iter_type lp_ff [0:LOOP_STAGES];

   always_comb begin
      lp_in[0]         = s3_ff;
      lp_in[0].l2      = sqr_ff[0] + sqr_ff[1] + sqr_ff[2];
      lp_in[0].sq_rem  = '0;
      lp_in[0].sq_root = '0;
   end

   for (genvar k = 1; k <= LOOP_STAGES; k++) begin : g_loop
      always_comb begin
         iter_type           t;
         logic [35:0]        trial;
         logic signed [33:0] nx;
         int                 step;
         t  = lp_ff[k-1];
         nx = '0;
         for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            step     = (k - 1) * STEPS_PER_STAGE + s;
            trial    = {2'b00, t.sq_root, 2'b01};
            t.sq_rem = {t.sq_rem[33:0], t.l2[63:62]};
            t.l2     = {t.l2[61:0], 2'b00};
            if (t.sq_rem >= trial) begin
               t.sq_rem  = t.sq_rem - trial;
               t.sq_root = {t.sq_root[30:0], 1'b1};
            end else begin
               t.sq_root = {t.sq_root[30:0], 1'b0};
            end
            if (step < CORDIC_STEPS) begin
               if (!t.cz[32]) begin
                  nx   = t.cx - (t.cy >>> step);
                  t.cy = t.cy + (t.cx >>> step);
                  t.cz = t.cz - $signed({3'b000, atan_turn(step[4:0])});
               end else begin
                  nx   = t.cx + (t.cy >>> step);
                  t.cy = t.cy - (t.cx >>> step);
                  t.cz = t.cz + $signed({3'b000, atan_turn(step[4:0])});
               end
               t.cx = nx;
            end
         end
         lp_in[k] = t;
      end
   end

   for (genvar k = 0; k <= LOOP_STAGES; k++) begin : g_loop_reg
      always_ff @(posedge clock) begin
         if (ce) lp_ff[k] <= lp_in[k];
      end
   end

   // quadrant mapping, then division stages for the unit axis
   div_type dv_in [0:DIV_STAGES];
   div_type dv_ff [0:DIV_STAGES];

   always_comb begin
      iter_type           t;
      logic signed [33:0] c34;
      logic signed [33:0] s34;
      t = lp_ff[LOOP_STAGES];
      case (t.quad)
         QUAD_0: begin
            c34 = t.cx;
            s34 = t.cy;
         end
         QUAD_1: begin
            c34 = -t.cy;
            s34 = t.cx;
         end
         QUAD_2: begin
            c34 = -t.cx;
            s34 = -t.cy;
         end
         default: begin
            c34 = t.cy;
            s34 = -t.cx;
         end
      endcase
      dv_in[0].cr   = t.cr;
      dv_in[0].root = t.sq_root;
      dv_in[0].cosv = clamp_q30(c34);
      dv_in[0].sinv = clamp_q30(s34);
      for (int l = 0; l < 3; l++) begin
         dv_in[0].rem[l] = {2'b00, t.cr.amag[l][31:1]};
         dv_in[0].quo[l] = '0;
      end
   end

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      always_comb begin
         div_type t;
         int      step;
         t = dv_ff[k-1];
         for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            step = (k - 1) * STEPS_PER_STAGE + s;
            if (step < DIV_STEPS) begin
               for (int l = 0; l < 3; l++) begin
                  t.rem[l] = {t.rem[l][31:0], (step == 0) ? t.cr.amag[l][0] : 1'b0};
                  if (t.rem[l] >= {1'b0, t.root}) begin
                     t.rem[l] = t.rem[l] - {1'b0, t.root};
                     t.quo[l] = {t.quo[l][29:0], 1'b1};
                  end else begin
                     t.quo[l] = {t.quo[l][29:0], 1'b0};
                  end
               end
            end
         end
         dv_in[k] = t;
      end
   end

   for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (ce) dv_ff[k] <= dv_in[k];
      end
   end

   // signed unit axis and half of one minus cosine
   div_type            dl;
   logic [2:0][31:0]   u_in, u_ff;
   logic [33:0]        omc_full;
   logic [2:0][31:0]   vecp_ff;
   logic signed [31:0] cosp_ff, sinp_ff;
   logic [31:0]        omc_ff;
   logic               zp_ff;

   assign dl       = dv_ff[DIV_STAGES];
   assign omc_full = 34'(ONE_Q30 - 34'(dl.cosv) + 34'sd1);

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         u_in[l] = dl.cr.aneg[l] ? (32'd0 - {1'b0, dl.quo[l]}) : {1'b0, dl.quo[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         u_ff    <= u_in;
         vecp_ff <= dl.cr.vec;
         cosp_ff <= dl.cosv;
         sinp_ff <= dl.sinv;
         omc_ff  <= omc_full[32:1];
         zp_ff   <= dl.cr.zero;
      end
   end

   // products for dot, cross and v*cos
   logic [2:0][63:0]   dot_in, dot_ff, vc_in, vc_ff;
   logic [5:0][63:0]   crs_in, crs_ff;
   logic [2:0][31:0]   u1_ff;
   logic signed [31:0] sin1_ff;
   logic [31:0]        omc1_ff;
   logic               z1_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         dot_in[l] = $signed(u_ff[l]) * $signed(vecp_ff[l]);
         vc_in[l]  = $signed(vecp_ff[l]) * cosp_ff;
      end
      crs_in[0] = $signed(u_ff[1]) * $signed(vecp_ff[2]);
      crs_in[1] = $signed(u_ff[2]) * $signed(vecp_ff[1]);
      crs_in[2] = $signed(u_ff[2]) * $signed(vecp_ff[0]);
      crs_in[3] = $signed(u_ff[0]) * $signed(vecp_ff[2]);
      crs_in[4] = $signed(u_ff[0]) * $signed(vecp_ff[1]);
      crs_in[5] = $signed(u_ff[1]) * $signed(vecp_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         dot_ff  <= dot_in;
         vc_ff   <= vc_in;
         crs_ff  <= crs_in;
         u1_ff   <= u_ff;
         sin1_ff <= sinp_ff;
         omc1_ff <= omc_ff;
         z1_ff   <= zp_ff;
      end
   end

   // rescale dot, cross and v*cos
   logic signed [63:0] dsum;
   logic [2:0][63:0]   wsum;
   logic [34:0]        d_ff;
   logic [2:0][34:0]   w_in, w_ff;
   logic [2:0][32:0]   vcr_in, vcr_ff;
   logic [2:0][31:0]   u2_ff;
   logic signed [31:0] sin2_ff;
   logic [31:0]        omc2_ff;
   logic               z2_ff;

   always_comb begin
      logic signed [63:0] tmp;
      dsum    = $signed(dot_ff[0]) + $signed(dot_ff[1]) + $signed(dot_ff[2]);
      wsum[0] = $signed(crs_ff[0]) - $signed(crs_ff[1]);
      wsum[1] = $signed(crs_ff[2]) - $signed(crs_ff[3]);
      wsum[2] = $signed(crs_ff[4]) - $signed(crs_ff[5]);
      for (int l = 0; l < 3; l++) begin
         tmp       = rnd_shift($signed(wsum[l]), 5'd30);
         w_in[l]   = tmp[34:0];
         tmp       = rnd_shift($signed(vc_ff[l]), 5'd30);
         vcr_in[l] = tmp[32:0];
      end
   end

   always_ff @(posedge clock) begin
      logic signed [63:0] dr;
      if (ce) begin
         dr      = rnd_shift(dsum, 5'd30);
         d_ff    <= dr[34:0];
         w_ff    <= w_in;
         vcr_ff  <= vcr_in;
         u2_ff   <= u1_ff;
         sin2_ff <= sin1_ff;
         omc2_ff <= omc1_ff;
         z2_ff   <= z1_ff;
      end
   end

   // u*d and w*sin
   logic [2:0][63:0] ud_in, ud_ff, ws_in, ws_ff;
   logic [2:0][32:0] vcr3_ff;
   logic [31:0]      omc3_ff;
   logic             z3_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         ud_in[l] = $signed(u2_ff[l]) * $signed(d_ff);
         ws_in[l] = $signed(w_ff[l]) * sin2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         ud_ff   <= ud_in;
         ws_ff   <= ws_in;
         vcr3_ff <= vcr_ff;
         omc3_ff <= omc2_ff;
         z3_ff   <= z2_ff;
      end
   end

   // rescale u*d and w*sin
   logic [2:0][34:0] t_in, t_ff, wsr_in, wsr_ff;
   logic [2:0][32:0] vcr4_ff;
   logic [31:0]      omc4_ff;
   logic             z4_ff;

   always_comb begin
      logic signed [63:0] tmp;
      for (int l = 0; l < 3; l++) begin
         tmp       = rnd_shift($signed(ud_ff[l]), 5'd30);
         t_in[l]   = tmp[34:0];
         tmp       = rnd_shift($signed(ws_ff[l]), 5'd30);
         wsr_in[l] = tmp[34:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         t_ff    <= t_in;
         wsr_ff  <= wsr_in;
         vcr4_ff <= vcr3_ff;
         omc4_ff <= omc3_ff;
         z4_ff   <= z3_ff;
      end
   end

   // t * (1 - cos)/2
   logic [2:0][63:0] tm_in, tm_ff;
   logic [2:0][34:0] wsr5_ff;
   logic [2:0][32:0] vcr5_ff;
   logic             z5_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         tm_in[l] = $signed(t_ff[l]) * $signed({1'b0, omc4_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         tm_ff   <= tm_in;
         wsr5_ff <= wsr_ff;
         vcr5_ff <= vcr4_ff;
         z5_ff   <= z4_ff;
      end
   end

   // final sum, saturation, output register
   logic [2:0][31:0] out_in, out_ff;
   logic             clip_in, clip_ff, zero_ff;

   always_comb begin
      logic signed [63:0] tr;
      logic signed [39:0] o;
      clip_in = 1'b0;
      for (int l = 0; l < 3; l++) begin
         tr = rnd_shift($signed(tm_ff[l]), 5'd29);
         o  = 40'($signed(vcr5_ff[l])) + 40'($signed(wsr5_ff[l])) + tr[39:0];
         if (o > 40'sd2147483647) begin
            out_in[l] = 32'h7FFFFFFF;
            clip_in   = 1'b1;
         end else if (o < -40'sd2147483648) begin
            out_in[l] = 32'h80000000;
            clip_in   = 1'b1;
         end else begin
            out_in[l] = o[31:0];
         end
      end
      if (z5_ff) begin
         out_in  = '0;
         clip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         out_ff  <= out_in;
         clip_ff <= clip_in;
         zero_ff <= z5_ff;
      end
   end

   assign rsp_tdata = out_ff;
   assign rsp_tuser = {clip_ff, zero_ff};

   `VAAR_ASSERT_IMPLY(a_zero_result, clock, reset, rsp_tvalid && rsp_tuser[0],
      rsp_tdata == 96'd0 && !rsp_tuser[1], "zero axis item carries data or clip")
   `VAAR_ASSERT_IMPLY(a_stall_holds_input, clock, reset, rsp_tvalid && !rsp_tready,
      !req_tready, "input taken while output stalled")
   `VAAR_ASSERT_IMPLY(a_empty_out_ready, clock, reset, !rsp_tvalid,
      req_tready, "input refused with empty output")

endmodule
